// ===== design/mpts_pkg.sv =====
// Shared types, codes and position helpers for the memory pattern test sequencer.
// Used by mpts_req_gen, mpts_seq and memory_pattern_test_sequencer_core.
// No dependencies.
package mpts_pkg;

    // Sizing of the tested region
    localparam int MAX_BYTES_LOG2 = 26;
    localparam int LEN_W          = MAX_BYTES_LOG2 + 1;
    localparam int CFG_LEN_W      = 27;
    localparam int CMP_W          = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
    localparam logic [LEN_W-1:0] LEN_LIMIT = {1'b1, {MAX_BYTES_LOG2{1'b0}}};

    // Patterns
    localparam logic [31:0] PAT_FILL = 32'h1234_5678;
    localparam logic [31:0] PAT_55   = 32'h5555_5555;
    localparam logic [31:0] PAT_AA   = 32'hAAAA_AAAA;
    localparam logic [31:0] MASK_B   = 32'h0000_00FF;
    localparam logic [31:0] MASK_H   = 32'h0000_FFFF;
    localparam logic [31:0] MASK_W   = 32'hFFFF_FFFF;
    localparam logic [31:0] FULL_ERR_CAP = 32'd10;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_LEN   = 2'd1;
    localparam logic [1:0] CFG_MODES = 2'd2;

    // Input function codes
    localparam logic [1:0] FN_START = 2'd0;
    localparam logic [1:0] FN_WACK  = 2'd1;
    localparam logic [1:0] FN_RDATA = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    // Access sizes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Access units of the full pass: bytes 0..3, halfwords 4..5, word 6
    localparam logic [2:0] UNIT_HALF0 = 3'd4;
    localparam logic [2:0] UNIT_HALF1 = 3'd5;
    localparam logic [2:0] UNIT_WORD  = 3'd6;
    localparam logic [2:0] STEP_LAST  = 3'd5;
    localparam logic [2:0] STEP_INC   = 3'd4;
    localparam logic [2:0] PAIR_LAST  = 3'd3;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_FILL = 5'b00010,
        PH_READ = 5'b00100,
        PH_PAIR = 5'b01000,
        PH_FULL = 5'b10000
    } t_phase;

    typedef struct packed {
        t_phase           phase;
        logic [LEN_W-1:0] offset;
        logic [LEN_W-1:0] outer;
        logic [2:0]       unit;
        logic [2:0]       step;
    } t_pos;

    typedef struct packed {
        logic [31:0]          base;
        logic [CFG_LEN_W-1:0] len;
        logic [4:0]           modes;
    } t_cfg;

    typedef struct packed {
        logic        rd;
        logic [31:0] addr;
        logic [1:0]  size;
        logic [31:0] val;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [1:0]  size;
        logic [31:0] data;
        logic [31:0] err;
        logic        busy;
    } t_result;

    typedef struct packed {
        logic       found;
        logic [2:0] idx;
    } t_find;

    function automatic logic unit_on(logic [4:0] modes, logic [2:0] u);
        logic on;
        if (u < UNIT_HALF0)     on = modes[0];
        else if (u < UNIT_WORD) on = modes[1];
        else                    on = modes[2];
        return on;
    endfunction

    function automatic logic step_on(logic [4:0] modes, logic [2:0] s);
        logic on;
        if (s < STEP_INC) on = modes[3];
        else              on = modes[4];
        return on;
    endfunction

    // First enabled step within a unit
    function automatic t_find first_step(logic [4:0] modes);
        t_find f;
        f.found = modes[3] | modes[4];
        f.idx   = modes[3] ? 3'd0 : STEP_INC;
        return f;
    endfunction

    // Next enabled step after s within the same unit
    function automatic t_find next_step(logic [4:0] modes, logic [2:0] s);
        t_find      f;
        logic [3:0] t;
        t = {1'b0, s} + 4'd1;
        f = '0;
        if (t <= 4'(PAIR_LAST) && modes[3]) begin
            f.found = 1'b1;
            f.idx   = t[2:0];
        end else if (t <= 4'(STEP_LAST) && modes[4]) begin
            f.found = 1'b1;
            f.idx   = (t < 4'(STEP_INC)) ? STEP_INC : t[2:0];
        end
        return f;
    endfunction

    // Lowest enabled unit above u (or from zero when all is set)
    function automatic t_find next_unit(logic [4:0] modes, logic [2:0] u, logic all);
        t_find f;
        f = '0;
        for (int k = 6; k >= 0; k--) begin
            if ((all || 3'(k) > u) && unit_on(modes, 3'(k))) begin
                f.found = 1'b1;
                f.idx   = 3'(k);
            end
        end
        return f;
    endfunction

endpackage

// ===== design/memory_pattern_test_sequencer_core.sv =====
// Top level of the memory pattern test sequencer: stream ports, configuration
// registers, input register and result register. Depends on mpts_pkg and mpts_seq.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: func[1:0]; tdata: read_data[31:0]
//  m_axis    out        tuser: req_kind[1:0]; tdata: req_addr, req_size, req_data,
//                       error_count, busy_res (from bit 0 up), zero padded to 104
//  i_cfg_*   in         write enable, register index, 32-bit write data
//
// One transaction in and one out per cycle while the output does not stall; an
// accepted input goes to the input register, then to the result register.
// The run state updates in the same cycle the result register loads, so the
// next item sees it straight away. Reset is synchronous and clears the run
// state, the error count, the configuration and both stage valids.
// A stalled output holds its result; the input register still takes one more
// item, then the input side stalls too.
module memory_pattern_test_sequencer_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,   // func
    input  logic [31:0]  s_axis_tdata,   // read_data
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [1:0]   m_axis_tuser,   // req_kind
    output logic [103:0] m_axis_tdata    // req_addr, req_size, req_data, error_count,
                                         // busy_res, zero pad
);
    import mpts_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_vld;
    logic [1:0]  r_in_func;
    logic [31:0] r_in_rdata;
    logic        r_out_vld;
    t_result     r_out;
    t_result     w_res;
    logic        w_fire;

    // Process the held item whenever the result register is free
    assign w_fire        = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_fire;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BASE:  r_cfg.base  <= i_cfg_wdata;
                CFG_LEN:   r_cfg.len   <= i_cfg_wdata[CFG_LEN_W-1:0];
                CFG_MODES: r_cfg.modes <= i_cfg_wdata[4:0];
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func  <= s_axis_tuser;
            r_in_rdata <= s_axis_tdata;
        end
    end

    mpts_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_func  (r_in_func),
        .i_rdata (r_in_rdata),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {5'd0, r_out.busy, r_out.err, r_out.data, r_out.size, r_out.addr};

endmodule

// ===== design/mpts_req_gen.sv =====
// Request decode: turns a test position into address, size and pattern value.
// Depends on mpts_pkg.
module mpts_req_gen (
    input  mpts_pkg::t_pos  i_pos,
    input  logic [31:0]     i_base,
    output mpts_pkg::t_req  o_req
);
    import mpts_pkg::*;

    logic [31:0] w_off;
    logic [2:0]  w_uoff;
    logic [2:0]  w_j;
    logic [31:0] w_mask;
    logic [31:0] w_pat;

    assign w_off = 32'(i_pos.offset);

    // Unit byte offset, increment and lane mask in the full pass
    always_comb begin
        w_uoff = 3'd0;
        w_j    = 3'd0;
        w_mask = MASK_W;
        if (i_pos.unit < UNIT_HALF0) begin
            w_uoff = i_pos.unit;
            w_j    = 3'd4 - i_pos.unit;
            w_mask = MASK_B;
        end else if (i_pos.unit < UNIT_WORD) begin
            w_uoff = (i_pos.unit == UNIT_HALF1) ? 3'd2 : 3'd0;
            w_j    = 3'd6 - i_pos.unit;
            w_mask = MASK_H;
        end
    end

    // Full-pass pattern before masking
    always_comb begin
        if (i_pos.step < 3'd2)          w_pat = PAT_55;
        else if (i_pos.step < STEP_INC) w_pat = PAT_AA;
        else                            w_pat = 32'(i_pos.outer) + 32'(w_j);
    end

    // Describe the access at this position
    always_comb begin
        o_req      = '0;
        o_req.addr = i_base + w_off;
        o_req.size = SIZE_WORD;
        case (i_pos.phase)
            PH_FILL: begin
                o_req.val = PAT_FILL;
            end
            PH_READ: begin
                o_req.val = PAT_FILL;
                o_req.rd  = 1'b1;
            end
            PH_PAIR: begin
                o_req.val = (i_pos.step < 3'd2) ? PAT_55 : PAT_AA;
                o_req.rd  = i_pos.step[0];
            end
            PH_FULL: begin
                o_req.addr = i_base + w_off + 32'(w_uoff);
                o_req.val  = w_pat & w_mask;
                o_req.rd   = i_pos.step[0];
                if (i_pos.unit < UNIT_HALF0)     o_req.size = SIZE_BYTE;
                else if (i_pos.unit < UNIT_WORD) o_req.size = SIZE_HALF;
            end
            default: begin
                o_req = '0;
            end
        endcase
    end

endmodule

// ===== design/mpts_seq.sv =====
// Test sequencer: run state, response checking, error count and next request.
// Depends on mpts_pkg and mpts_req_gen.
module mpts_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [1:0]        i_func,
    input  logic [31:0]       i_rdata,
    input  mpts_pkg::t_cfg    i_cfg,
    output mpts_pkg::t_result o_res
);
    import mpts_pkg::*;

    t_pos             r_pos,    n_pos;
    logic [31:0]      r_base,   n_base;
    logic [LEN_W-1:0] r_len,    n_len;
    logic [4:0]       r_modes,  n_modes;
    logic [31:0]      r_err,    n_err;
    logic [31:0]      r_expect, n_expect;

    logic             w_pend_rd;
    logic             w_resp_ok;
    logic [31:0]      w_mask;
    logic             w_mism;
    logic [LEN_W:0]   w_off4;
    logic             w_wrap;
    logic [LEN_W-1:0] w_outer4;
    logic [LEN_W-1:0] w_len_clamp;
    t_find            w_nstep, w_nunit, w_fstep, w_funit;
    logic             w_emit;
    logic             w_done;
    t_req             w_req;

    // Response classification against the pending access
    always_comb begin
        w_pend_rd = (r_pos.phase == PH_READ) ||
                    (((r_pos.phase == PH_PAIR) || (r_pos.phase == PH_FULL)) && r_pos.step[0]);
        w_resp_ok = (r_pos.phase != PH_IDLE) &&
                    ((w_pend_rd && (i_func == FN_RDATA)) ||
                     (!w_pend_rd && (i_func == FN_WACK)));
        w_mask = MASK_W;
        if (r_pos.phase == PH_FULL) begin
            if (r_pos.unit < UNIT_HALF0)     w_mask = MASK_B;
            else if (r_pos.unit < UNIT_WORD) w_mask = MASK_H;
        end
        w_mism = w_pend_rd && ((i_rdata & w_mask) != r_expect);
    end

    // Position arithmetic shared by the phases
    always_comb begin
        w_off4   = {1'b0, r_pos.offset} + (LEN_W+1)'(4);
        w_wrap   = w_off4 >= {1'b0, r_len};
        w_outer4 = r_pos.outer - LEN_W'(4);
        w_nstep  = next_step(r_modes, r_pos.step);
        w_nunit  = next_unit(r_modes, r_pos.unit, 1'b0);
        w_fstep  = first_step(r_modes);
        w_funit  = next_unit(r_modes, r_pos.unit, 1'b1);
        if (CMP_W'(i_cfg.len) > CMP_W'(LEN_LIMIT)) w_len_clamp = LEN_LIMIT;
        else                                      w_len_clamp = LEN_W'(i_cfg.len);
        w_len_clamp[1:0] = 2'b00;
    end

    // Next run state
    always_comb begin
        n_pos   = r_pos;
        n_base  = r_base;
        n_len   = r_len;
        n_modes = r_modes;
        n_err   = r_err;
        w_emit  = 1'b0;
        w_done  = 1'b0;
        if (i_func == FN_START) begin
            // Start or restart a run from the current registers
            n_base  = i_cfg.base;
            n_len   = w_len_clamp;
            n_modes = i_cfg.modes;
            n_err   = '0;
            n_pos   = '0;
            if (w_len_clamp == '0) begin
                n_pos.phase = PH_IDLE;
                w_done      = 1'b1;
            end else begin
                n_pos.phase = PH_FILL;
                w_emit      = 1'b1;
            end
        end else if (w_resp_ok) begin
            // Count a mismatch
            if (w_mism) begin
                if (r_pos.phase == PH_FULL) begin
                    if (r_err < FULL_ERR_CAP) n_err = r_err + 32'd1;
                end else if (r_err != MASK_W) begin
                    n_err = r_err + 32'd1;
                end
            end
            w_emit = 1'b1;
            case (r_pos.phase)
                PH_FILL, PH_READ: begin
                    n_pos.offset = w_off4[LEN_W-1:0];
                    if (w_wrap) begin
                        n_pos.offset = '0;
                        n_pos.step   = '0;
                        n_pos.phase  = (r_pos.phase == PH_FILL) ? PH_READ : PH_PAIR;
                    end
                end
                PH_PAIR: begin
                    n_pos.step = r_pos.step + 3'd1;
                    if (r_pos.step == PAIR_LAST) begin
                        n_pos.step   = '0;
                        n_pos.offset = w_off4[LEN_W-1:0];
                        if (w_wrap) begin
                            n_pos.phase  = PH_FULL;
                            n_pos.offset = '0;
                            n_pos.outer  = r_len;
                            n_pos.unit   = w_funit.idx;
                            n_pos.step   = w_fstep.idx;
                            if (!(w_funit.found && w_fstep.found)) begin
                                n_pos.phase = PH_IDLE;
                                w_emit      = 1'b0;
                                w_done      = 1'b1;
                            end
                        end
                    end
                end
                PH_FULL: begin
                    if (w_nstep.found) begin
                        n_pos.step = w_nstep.idx;
                    end else if (w_nunit.found) begin
                        n_pos.unit = w_nunit.idx;
                        n_pos.step = w_fstep.idx;
                    end else begin
                        n_pos.outer  = w_outer4;
                        n_pos.offset = w_off4[LEN_W-1:0];
                        n_pos.unit   = w_funit.idx;
                        n_pos.step   = w_fstep.idx;
                        if (w_outer4 == '0) begin
                            n_pos.phase = PH_IDLE;
                            w_emit      = 1'b0;
                            w_done      = 1'b1;
                        end
                    end
                end
                default: begin
                    n_pos.phase = PH_IDLE;
                    w_emit      = 1'b0;
                    w_done      = 1'b1;
                end
            endcase
        end
    end

    mpts_req_gen u_req_gen (
        .i_pos  (n_pos),
        .i_base (n_base),
        .o_req  (w_req)
    );

    // Assemble the result transaction
    always_comb begin
        o_res      = '0;
        o_res.err  = n_err;
        o_res.busy = (n_pos.phase != PH_IDLE);
        n_expect   = r_expect;
        if (w_emit) begin
            o_res.kind = w_req.rd ? KIND_READ : KIND_WRITE;
            o_res.addr = w_req.addr;
            o_res.size = w_req.size;
            o_res.data = w_req.rd ? 32'd0 : w_req.val;
            n_expect   = w_req.val;
        end else if (w_done) begin
            o_res.kind = KIND_DONE;
        end
    end

    // Hold run state, advance on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '{phase: PH_IDLE, default: '0};
            r_base      <= '0;
            r_len       <= '0;
            r_modes     <= '0;
            r_err       <= '0;
            r_expect    <= '0;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_base   <= n_base;
            r_len    <= n_len;
            r_modes  <= n_modes;
            r_err    <= n_err;
            r_expect <= n_expect;
        end
    end

`ifndef SYNTHESIS
    a_offset_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos.phase != PH_IDLE) |-> (r_pos.offset < r_len))
        else $error("test offset beyond run length");

    a_full_counts_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos.phase == PH_FULL) |-> (LEN_W'(r_pos.offset + r_pos.outer) == r_len))
        else $error("full-pass counters out of step");

    a_full_pos_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos.phase == PH_FULL) |-> (unit_on(r_modes, r_pos.unit) &&
            step_on(r_modes, r_pos.step) && (r_pos.step <= STEP_LAST)))
        else $error("full pass sits on a disabled access");

    a_start_clears_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_func == FN_START)) |=> (r_err == 32'd0))
        else $error("error count not cleared by start");
`endif

endmodule

// ===== tb/mpts_tb_pkg.sv =====
// Request scoreboard for the memory pattern test sequencer: tracks the run state
// from every accepted memory response and checks each request against it.
// Depends on mpts_pkg.
package mpts_tb_pkg;

    import mpts_pkg::*;

    // func code that the block must ignore
    localparam logic [1:0] FN_BAD = 2'd3;

    class req_scoreboard;

        // Register values as written, and the copies taken at start
        logic [31:0]          set_base;
        logic [CFG_LEN_W-1:0] set_len;
        logic [4:0]           set_modes;
        logic [31:0]          run_base;
        logic [LEN_W-1:0]     run_len;
        logic [4:0]           run_modes;

        // Position of the run
        t_phase           ph;
        logic [LEN_W-1:0] offset;
        logic [LEN_W-1:0] outer;
        int unsigned      unit;
        int unsigned      step;
        logic [31:0]      want_val;
        logic [31:0]      err_total;

        t_result     expected_requests[$];
        int unsigned failures;

        function new();
            set_base  = '0;
            set_len   = '0;
            set_modes = '0;
            run_base  = '0;
            run_len   = '0;
            run_modes = '0;
            ph        = PH_IDLE;
            offset    = '0;
            outer     = '0;
            unit      = 0;
            step      = 0;
            want_val  = '0;
            err_total = '0;
            failures  = 0;
        endfunction

        function void set_settings(logic [31:0] base, logic [CFG_LEN_W-1:0] len,
                                   logic [4:0] modes);
            set_base  = base;
            set_len   = len;
            set_modes = modes;
        endfunction

        function bit busy();
            return ph != PH_IDLE;
        endfunction

        function int unsigned outstanding();
            return expected_requests.size();
        endfunction

        function logic [31:0] expected_data();
            return want_val;
        endfunction

        function bit width_enabled(int unsigned u);
            if (u < 4) return run_modes[0];
            if (u < 6) return run_modes[1];
            return run_modes[2];
        endfunction

        function bit pattern_enabled(int unsigned s);
            if (s < 4) return run_modes[3];
            return run_modes[4];
        endfunction

        // Move forward from the current unit and step, inclusive, to an enabled pair
        function bit seek();
            while (unit <= 6) begin
                if (width_enabled(unit) && pattern_enabled(step)) return 1'b1;
                step++;
                if (step > 5) begin
                    step = 0;
                    unit++;
                end
            end
            return 1'b0;
        endfunction

        function bit read_pending();
            if (ph == PH_READ) return 1'b1;
            if (ph == PH_PAIR || ph == PH_FULL) return (step % 2) == 1;
            return 1'b0;
        endfunction

        function logic [31:0] lane_mask();
            if (ph == PH_FULL && unit < 4) return MASK_B;
            if (ph == PH_FULL && unit < 6) return MASK_H;
            return MASK_W;
        endfunction

        // Step to the next access; drop to idle when the run is over
        function bit advance();
            bit more;
            more = 1'b1;
            case (ph)
                PH_FILL: begin
                    offset += 4;
                    if (offset >= run_len) begin
                        ph     = PH_READ;
                        offset = '0;
                    end
                end
                PH_READ: begin
                    offset += 4;
                    if (offset >= run_len) begin
                        ph     = PH_PAIR;
                        offset = '0;
                        step   = 0;
                    end
                end
                PH_PAIR: begin
                    step++;
                    if (step > 3) begin
                        step = 0;
                        offset += 4;
                        if (offset >= run_len) begin
                            ph     = PH_FULL;
                            offset = '0;
                            outer  = run_len;
                            unit   = 0;
                            step   = 0;
                            more   = seek();
                        end
                    end
                end
                PH_FULL: begin
                    step++;
                    if (step > 5) begin
                        step = 0;
                        unit++;
                    end
                    if (!seek()) begin
                        outer  -= 4;
                        offset += 4;
                        unit   = 0;
                        step   = 0;
                        more   = (outer != '0) && seek();
                    end
                end
                default: more = 1'b0;
            endcase
            if (!more) ph = PH_IDLE;
            return more;
        endfunction

        // Fill in the request for the current position and note the value to compare
        function void describe(inout t_result r);
            logic [31:0] addr;
            logic [31:0] mask;
            logic [31:0] val;
            logic [1:0]  size;
            bit          rd;
            int unsigned j;
            addr = run_base + 32'(offset);
            size = SIZE_WORD;
            mask = MASK_W;
            if (ph == PH_FILL || ph == PH_READ) begin
                val = PAT_FILL;
                rd  = (ph == PH_READ);
            end else if (ph == PH_PAIR) begin
                val = (step < 2) ? PAT_55 : PAT_AA;
                rd  = (step % 2) == 1;
            end else begin
                if (unit < 4) begin
                    size = SIZE_BYTE;
                    mask = MASK_B;
                    addr += 32'(unit);
                    j    = 4 - unit;
                end else if (unit < 6) begin
                    size = SIZE_HALF;
                    mask = MASK_H;
                    addr += 32'(2 * (unit - 4));
                    j    = 6 - unit;
                end else begin
                    j = 0;
                end
                if (step < 2)      val = PAT_55;
                else if (step < 4) val = PAT_AA;
                else               val = 32'(outer) + 32'(j);
                val = val & mask;
                rd  = (step % 2) == 1;
            end
            want_val = val;
            r.kind   = rd ? KIND_READ : KIND_WRITE;
            r.addr   = addr;
            r.size   = size;
            r.data   = rd ? 32'h0 : val;
        endfunction

        // Work out the request that an accepted response causes
        function void take_response(logic [1:0] func, logic [31:0] rdata);
            t_result          r;
            logic [LEN_W-1:0] clamped;
            bit               rd;
            r = '0;
            if (func == FN_START) begin
                clamped   = (set_len > LEN_LIMIT) ? LEN_LIMIT : LEN_W'(set_len);
                run_len   = {clamped[LEN_W-1:2], 2'b00};
                run_base  = set_base;
                run_modes = set_modes;
                err_total = '0;
                offset    = '0;
                outer     = '0;
                unit      = 0;
                step      = 0;
                want_val  = '0;
                if (run_len == '0) begin
                    ph     = PH_IDLE;
                    r.kind = KIND_DONE;
                end else begin
                    ph = PH_FILL;
                    describe(r);
                end
            end else if (ph != PH_IDLE && func != FN_BAD) begin
                rd = read_pending();
                if ((rd && func == FN_RDATA) || (!rd && func == FN_WACK)) begin
                    // the full pass stops counting at its cap, elsewhere saturate
                    if (rd && (rdata & lane_mask()) != want_val) begin
                        if (ph == PH_FULL) begin
                            if (err_total < FULL_ERR_CAP) err_total++;
                        end else if (err_total != '1) begin
                            err_total++;
                        end
                    end
                    if (advance()) describe(r);
                    else           r.kind = KIND_DONE;
                end
            end
            r.err  = err_total;
            r.busy = (ph != PH_IDLE);
            expected_requests.push_back(r);
        endfunction

        // Compare one request transaction with the oldest prediction
        function void check_request(logic [1:0] kind, logic [103:0] tdata);
            t_result want;
            if (expected_requests.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected request: kind %0d tdata %h", kind, tdata);
                return;
            end
            want = expected_requests.pop_front();
            if (kind !== want.kind || tdata[31:0] !== want.addr
                    || tdata[33:32] !== want.size || tdata[65:34] !== want.data
                    || tdata[97:66] !== want.err || tdata[98] !== want.busy
                    || tdata[103:99] !== 5'd0) begin
                failures++;
                if (failures <= 10) begin
                    $display("request mismatch: expected kind %0d addr %h size %0d data %h",
                             want.kind, want.addr, want.size, want.data);
                    $display("  errors %0d busy %0b; got kind %0d addr %h size %0d data %h",
                             want.err, want.busy, kind, tdata[31:0], tdata[33:32],
                             tdata[65:34]);
                    $display("  errors %0d busy %0b pad %h",
                             tdata[97:66], tdata[98], tdata[103:99]);
                end
            end
        endfunction

    endclass

endpackage

// ===== tb/tb.sv =====
// Testbench top for memory_pattern_test_sequencer_core: acts as the memory,
// answering each predicted request, with random stalls on both streams.
// Depends on mpts_pkg and mpts_tb_pkg.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mpts_pkg::*;
    import mpts_tb_pkg::*;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_wr_en   = 1'b0;
    logic [1:0]   i_cfg_index   = 2'd0;
    logic [31:0]  i_cfg_wdata   = 32'd0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser  = 2'd0;   // func
    logic [31:0]  s_axis_tdata  = 32'd0;  // read_data
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [1:0]   m_axis_tuser;           // req_kind
    logic [103:0] m_axis_tdata;           // req_addr, req_size, req_data, error_count,
                                          // busy_res, zero pad

    // no idling on either side while set
    bit steady = 1'b0;

    req_scoreboard sb = new();

    memory_pattern_test_sequencer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Write all three registers, upper write-data bits random where unused
    task automatic load_settings(logic [31:0] base, logic [26:0] len, logic [4:0] modes);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_index <= CFG_LEN;
        i_cfg_wdata <= {5'($urandom), len};
        @(posedge i_clk);
        i_cfg_index <= CFG_MODES;
        i_cfg_wdata <= {27'($urandom), modes};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_settings(base, len, modes);
    endtask

    // Offer one response transaction, with random idle cycles ahead of it
    task automatic send_item(logic [1:0] func, logic [31:0] data);
        while (!steady && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.take_response(func, data);
    endtask

    // Answer the pending request correctly, or with corrupted read data
    task automatic answer(bit corrupt);
        logic [31:0] d;
        logic [31:0] mask;
        logic [31:0] flip;
        d = $urandom;
        if (sb.read_pending()) begin
            mask = sb.lane_mask();
            flip = corrupt ? ($urandom & mask) : 32'h0;
            if (corrupt && flip == 32'h0) flip = 32'h1;
            d = (d & ~mask) | ((sb.expected_data() ^ flip) & mask);
            send_item(FN_RDATA, d);
        end else begin
            send_item(FN_WACK, d);
        end
    endtask

    // Response of the wrong kind, or the unused func code
    task automatic send_noise();
        if ($urandom_range(1) == 0) send_item(FN_BAD, $urandom);
        else if (sb.read_pending()) send_item(FN_WACK, $urandom);
        else send_item(FN_RDATA, $urandom);
    endtask

    // Hold off until every predicted request has come out, then let the pipe empty
    task automatic settle();
        int unsigned waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (6) @(posedge i_clk);
    endtask

    // Result side: check each request transaction, stall at random
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_request(m_axis_tuser, m_axis_tdata);
            m_axis_tready <= steady || ($urandom_range(99) >= 32);
        end
    end

    // Stimulus
    initial begin
        int unsigned taken;
        int unsigned n;
        int unsigned cap;
        int unsigned r;
        logic [31:0] base;
        logic [26:0] len;
        logic [4:0]  modes;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // responses while idle, then a length below one word
        load_settings(32'hFFFF_FFFC, 27'd3, 5'd0);
        send_item(FN_WACK, $urandom);
        send_item(FN_RDATA, 32'hFFFF_FFFF);
        send_item(FN_BAD, 32'h0);
        send_item(FN_START, $urandom);
        settle();

        // two words wrapping past the top of memory, nothing enabled for the full pass
        load_settings(32'hFFFF_FFFC, 27'd8, 5'd0);
        send_item(FN_START, 32'h0);
        answer(1'b0);
        send_item(FN_RDATA, $urandom);
        answer(1'b0);
        answer(1'b1);
        send_item(FN_BAD, $urandom);
        while (sb.busy()) answer(1'b0);
        settle();

        // oversized length with everything enabled, restarted mid-run
        load_settings(32'h0, 27'h7FF_FFFF, 5'h1F);
        send_item(FN_START, $urandom);
        repeat (3) answer(1'b0);
        send_item(FN_START, $urandom);
        answer(1'b1);
        settle();

        // random runs, a stretch in the middle without idling
        taken = 0;
        while (taken < 1300) begin
            steady <= (taken >= 450 && taken < 750);

            r = $urandom_range(99);
            if (r < 10)      base = 32'hFFFF_FFF0 + 32'($urandom_range(3) * 4);
            else if (r < 15) base = 32'h0;
            else if (r < 22) base = $urandom;
            else             base = $urandom & 32'hFFFF_FFFC;

            cap = 100000;
            r = $urandom_range(99);
            if (r < 5) begin
                len = 27'($urandom_range(3));
            end else if (r < 9) begin
                len = (r == 5) ? 27'(LEN_LIMIT)
                               : 27'($urandom_range(32'h7FF_FFFF, 32'h400_0000));
                cap = 40;
            end else if (r < 25) begin
                len = 27'($urandom_range(32, 4));
            end else begin
                len = 27'($urandom_range(12, 4));
            end

            r = $urandom_range(99);
            if (r < 10)      modes = 5'd0;
            else if (r < 22) modes = 5'h1F;
            else             modes = 5'($urandom_range(31));

            load_settings(base, len, modes);
            send_item(FN_START, $urandom);
            taken++;
            n = 1;
            while (sb.busy() && n < cap) begin
                r = $urandom_range(99);
                if (r < 2) begin
                    send_item(FN_START, $urandom);
                    taken++;
                end else if (r < 8) begin
                    send_noise();
                end else begin
                    answer($urandom_range(99) < 12);
                    taken++;
                end
                n++;
            end
            if (!sb.busy() && $urandom_range(99) < 25) send_noise();
            settle();
        end

        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
